### design/encoder_dimmer_lamp_control_core_macros.svh
// Assertion macros for the encoder dimmer lamp control core.
// Used by design files that assert; expects a clock named clk and reset rst.
`ifndef ENCODER_DIMMER_LAMP_CONTROL_CORE_MACROS_SVH
`define ENCODER_DIMMER_LAMP_CONTROL_CORE_MACROS_SVH

// Check a property outside of reset.
`define EDL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define EDL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/edl_pkg.sv
// Shared types and constants for the encoder dimmer lamp control core.
// No dependencies.
`timescale 1ns / 1ps

package edl_pkg;

  localparam int LEVEL_BITS = 8;
  localparam int MODE_BITS  = 2;

  localparam logic [LEVEL_BITS-1:0] MAX_LEVEL_RESET = LEVEL_BITS'(128);
  localparam logic [LEVEL_BITS-1:0] STEP_SIZE_RESET = LEVEL_BITS'(8);

  typedef enum logic {
    REG_MAX_LEVEL = 1'b0,
    REG_STEP_SIZE = 1'b1
  } reg_index_t;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_BOTH   = 2'd0,
    MODE_WHITE  = 2'd1,
    MODE_YELLOW = 2'd2
  } color_mode_t;

  typedef struct packed {
    logic func;
    logic enc_a;
    logic enc_b;
    logic power_button;
    logic mode_button;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic                  lamp_on;
    logic                  white_on;
    logic                  yellow_on;
    logic [MODE_BITS-1:0]  color_mode;
  } out_item_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] max_level;
    logic [LEVEL_BITS-1:0] step_size;
  } cfg_t;

  typedef struct packed {
    logic [1:0]            encoder_prev;
    logic                  power_key_prev;
    logic                  mode_key_prev;
    logic                  power_state;
    logic [LEVEL_BITS-1:0] bright_index;
    logic [MODE_BITS-1:0]  mode_state;
  } state_t;

endpackage

### design/encoder_dimmer_lamp_control_core.sv
// Encoder dimmer lamp control core: top level with registers and handshakes.
// Depends on edl_pkg, edl_next and encoder_dimmer_lamp_control_core_macros.svh.
`timescale 1ns / 1ps

// Takes one pin-change item per clock while out_ready allows, and returns one
// result item for each. An accepted item is held in the input register, where the lamp
// state, brightness and colour mode are updated; its result is then loaded into
// the result register, which raises out_valid, so the sustained rate is one item
// per cycle while out_ready stays high. A stalled result holds the
// input register, which then holds in_ready low until the result moves.
// Register writes take effect at the next edge and do not touch the level.
module encoder_dimmer_lamp_control_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  edl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output edl_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [edl_pkg::LEVEL_BITS-1:0] cfg_data
);
  import edl_pkg::*;

  cfg_t      cfg;
  state_t    st;
  state_t    st_next;
  out_item_t result;
  in_item_t  in_q;
  logic      in_vld_q;
  logic      process;

  assign process  = in_vld_q && (!out_valid || out_ready);
  assign in_ready = !in_vld_q || process;

  edl_next u_next (
    .cfg    (cfg),
    .st     (st),
    .item   (in_q),
    .nxt    (st_next),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_level <= MAX_LEVEL_RESET;
      cfg.step_size <= STEP_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_MAX_LEVEL: cfg.max_level <= cfg_data;
        REG_STEP_SIZE: cfg.step_size <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.encoder_prev   <= 2'b00;
      st.power_key_prev <= 1'b1;
      st.mode_key_prev  <= 1'b1;
      st.power_state    <= 1'b0;
      st.bright_index   <= MAX_LEVEL_RESET;
      st.mode_state     <= MODE_BOTH;
    end else if (process) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_data <= result;
    end
  end

`include "encoder_dimmer_lamp_control_core_macros.svh"

  `EDL_ASSERT(a_mode_range, out_valid |-> (out_data.color_mode != 2'd3), "color mode out of range")
  `EDL_ASSERT(a_enable_lamp, out_valid |-> ((!out_data.white_on && !out_data.yellow_on) || out_data.lamp_on), "channel enabled with lamp off")
  `EDL_ASSERT(a_off_level_hold, (process && !st_next.power_state) |=> (st.bright_index == $past(st.bright_index)), "level changed while lamp off")
  `EDL_ASSERT_ALWAYS(a_reset_empty, ($past(rst) && !rst) |-> (!out_valid && !in_vld_q), "pipeline not empty after reset")

endmodule

### design/edl_next.sv
// Next-state and result logic for one pin-change item.
// Depends on edl_pkg.
`timescale 1ns / 1ps

module edl_next (
  input  edl_pkg::cfg_t      cfg,
  input  edl_pkg::state_t    st,
  input  edl_pkg::in_item_t  item,
  output edl_pkg::state_t    nxt,
  output edl_pkg::out_item_t result
);
  import edl_pkg::*;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_DEC  = 2'd1,
    DIR_INC  = 2'd2
  } dir_t;

  localparam int WIDE_BITS = LEVEL_BITS + 2;

  logic [1:0]                  code;
  dir_t                        dir;
  logic                        power_next;
  logic [LEVEL_BITS-1:0]       b_dec;
  logic [LEVEL_BITS-1:0]       lvl_dec;
  logic [LEVEL_BITS:0]         b_sum;
  logic [LEVEL_BITS-1:0]       b_inc;
  logic [LEVEL_BITS-1:0]       lvl_inc;
  logic signed [WIDE_BITS-1:0] limit;
  logic signed [WIDE_BITS-1:0] b_wide;
  logic signed [WIDE_BITS-1:0] inc_wide;
  logic [MODE_BITS-1:0]        mode_inc;

  assign code = {item.enc_b, item.enc_a};

  always_comb begin
    unique case ({st.encoder_prev, code})
      4'b10_11, 4'b11_01, 4'b01_00, 4'b00_10: dir = DIR_INC;
      4'b01_11, 4'b11_10, 4'b10_00, 4'b00_01: dir = DIR_DEC;
      default:                                dir = DIR_NONE;
    endcase
  end

  // Decrease with snap to zero.
  assign b_dec   = (st.bright_index >= cfg.step_size) ?
                   (st.bright_index - cfg.step_size) : st.bright_index;
  assign lvl_dec = (b_dec < cfg.step_size) ? '0 : b_dec;

  // Increase with signed limit and snap to max.
  assign limit    = $signed({2'b00, cfg.max_level}) - $signed({2'b00, cfg.step_size});
  assign b_wide   = $signed({2'b00, st.bright_index});
  assign b_sum    = {1'b0, st.bright_index} + {1'b0, cfg.step_size};
  assign b_inc    = (b_wide <= limit) ? b_sum[LEVEL_BITS-1:0] : st.bright_index;
  assign inc_wide = $signed({2'b00, b_inc});
  assign lvl_inc  = (inc_wide >= limit) ? cfg.max_level : b_inc;

  assign mode_inc = (st.mode_state >= MODE_YELLOW) ? MODE_BOTH : (st.mode_state + 2'd1);

  assign power_next = st.power_state ^ (item.power_button & ~st.power_key_prev);

  always_comb begin
    nxt = st;
    if (!item.func) begin
      nxt.power_key_prev = item.power_button;
      nxt.power_state    = power_next;
      if (power_next && dir != DIR_NONE) begin
        nxt.encoder_prev = code;
        nxt.bright_index = (dir == DIR_DEC) ? lvl_dec : lvl_inc;
      end
    end else if (st.power_state) begin
      nxt.mode_key_prev = item.mode_button;
      if (item.mode_button && !st.mode_key_prev) begin
        nxt.mode_state = mode_inc;
      end
    end
  end

  always_comb begin
    result.level      = nxt.bright_index;
    result.lamp_on    = nxt.power_state;
    result.white_on   = nxt.power_state && (nxt.mode_state != MODE_YELLOW);
    result.yellow_on  = nxt.power_state && (nxt.mode_state != MODE_WHITE);
    result.color_mode = nxt.mode_state;
  end

endmodule
